// ===== hdl/tpl_pkg.sv =====
// Package: shared types, widths and datapath op codes for the tree path-length engine.
`default_nettype none

package tpl_pkg;

   // Default sizing of the tables
   localparam int MAX_NODES_DEF = 1024;
   localparam int LEVELS_DEF    = 11;

   // Field widths fixed by the word formats
   localparam int NODE_W = 10;
   localparam int TIME_W = 11;
   localparam int DIST_W = 32;
   localparam int LEN_W  = 33;

   // Command codes of an input word
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Input word
   typedef struct packed {
      logic              command;
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;
      logic [TIME_W-1:0] entry_time;
      logic [TIME_W-1:0] exit_time;
      logic [DIST_W-1:0] root_distance;
   } req_type;

   // Result word
   typedef struct packed {
      logic [NODE_W-1:0] common_ancestor;
      logic [LEN_W-1:0]  path_length;
   } rsp_type;

   // One row of the per-node table
   typedef struct packed {
      logic [TIME_W-1:0] entry_time;
      logic [TIME_W-1:0] exit_time;
      logic [DIST_W-1:0] root_distance;
   } node_rec_type;

   // Datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_NODE_WR,
      OP_FILL_RD,
      OP_FILL_WR,
      OP_RD_U,
      OP_RD_V,
      OP_PICK_U,
      OP_PICK_V,
      OP_CLIMB_START,
      OP_CLIMB_NODE,
      OP_CLIMB_TEST,
      OP_FIN_ANC,
      OP_FIN_NODE,
      OP_RSP_LOAD
   } dp_op_type;

   // Status flags from the datapath
   typedef struct packed {
      logic is_query;
      logic raw_ok;
      logic same_uv;
      logic cov_uv;
      logic cov_vu;
      logic lvl_zero;
      logic fill_last;
      logic one_level;
      logic rsp_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== hdl/tpl_datapath.sv =====
// Datapath: node and ancestor tables, query registers, length arithmetic, result register.
`default_nettype none

module tpl_datapath #(
   parameter int MAX_NODES = tpl_pkg::MAX_NODES_DEF,
   parameter int LEVELS    = tpl_pkg::LEVELS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire tpl_pkg::req_type       req_data,
   input  wire tpl_pkg::dp_op_type     op,
   output tpl_pkg::dp_status_type      status,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output tpl_pkg::rsp_type            rsp_data
);
   import tpl_pkg::*;

   localparam int AW     = $clog2(MAX_NODES);
   localparam int ADEPTH = MAX_NODES * LEVELS;
   localparam int AAW    = $clog2(ADEPTH);
   localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam logic [LW-1:0] TOP_LVL       = LW'(LEVELS - 1);
   localparam logic [LW-1:0] FILL_LAST_LVL = LW'((LEVELS > 1) ? LEVELS - 2 : 0);

   // Out-of-range node numbers stand for the sentinel node
   function automatic logic [AW-1:0] node_of(input logic [NODE_W-1:0] raw);
      logic [31:0] wide;
      wide = 32'(raw);
      if (wide >= 32'(MAX_NODES)) begin
         wide = '0;
      end
      return wide[AW-1:0];
   endfunction

   // Ancestor row address: node * LEVELS + level
   function automatic logic [AAW-1:0] anc_addr(input logic [AW-1:0] node,
                                               input logic [31:0]   lvl);
      logic [31:0] t;
      t = 32'(node) * 32'(LEVELS) + lvl;
      return t[AAW-1:0];
   endfunction

   // Tables
   node_rec_type   node_mem [MAX_NODES];
   logic [AW-1:0]  anc_mem  [ADEPTH];

   // Registers
   logic [AW-1:0]     u_ff, u_in;
   logic [AW-1:0]     v_ff, v_in;
   logic [AW-1:0]     cur_ff, cur_in;
   logic [AW-1:0]     l_ff, l_in;
   logic              raw_ok_ff, raw_ok_in;
   node_rec_type      ld_rec_ff, ld_rec_in;
   node_rec_type      u_rec_ff, u_rec_in;
   node_rec_type      v_rec_ff, v_rec_in;
   logic [LEN_W-1:0]  sum_ff, sum_in;
   logic [DIST_W-1:0] dl_ff, dl_in;
   logic [LW-1:0]     lvl_ff, lvl_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   node_rec_type      node_rd_ff;
   logic [AW-1:0]     anc_rd_ff;

   // Memory port controls
   logic              node_rd_en, node_wr_en;
   logic [AW-1:0]     node_rd_addr;
   logic              anc_rd_en, anc_wr_en;
   logic [AAW-1:0]    anc_rd_addr, anc_wr_addr;
   logic [AW-1:0]     anc_wr_data;

   // Query helpers
   logic              lvl_zero;
   logic              cov_w;
   logic [AW-1:0]     climb_u;
   logic [LW-1:0]     test_lvl;
   logic [LEN_W-1:0]  sub_len;
   logic [LEN_W-1:0]  len;
   logic [31:0]       l_wide;

   assign lvl_zero = (lvl_ff == '0);
   assign test_lvl = lvl_zero ? '0 : lvl_ff - 1'b1;

   // w keeps u below it unless w already covers v
   assign cov_w   = (node_rd_ff.entry_time <= v_rec_ff.entry_time) &&
                    (node_rd_ff.exit_time  >= v_rec_ff.exit_time);
   assign climb_u = cov_w ? u_ff : anc_rd_ff;

   // du + dv - 2*dl, floored at zero
   assign sub_len = {dl_ff, 1'b0};
   assign len     = (sum_ff >= sub_len) ? sum_ff - sub_len : '0;
   assign l_wide  = 32'(l_ff);

   // Memory port selection
   always_comb begin
      node_rd_en   = 1'b0;
      node_rd_addr = u_ff;
      node_wr_en   = 1'b0;
      anc_rd_en    = 1'b0;
      anc_rd_addr  = anc_addr(u_ff, 32'd0);
      anc_wr_en    = 1'b0;
      anc_wr_addr  = anc_addr(u_ff, 32'd0);
      anc_wr_data  = v_ff;
      case (op)
         OP_NODE_WR: begin
            node_wr_en = 1'b1;
            anc_wr_en  = 1'b1;
         end
         OP_FILL_RD: begin
            anc_rd_en   = 1'b1;
            anc_rd_addr = anc_addr(cur_ff, 32'(lvl_ff));
         end
         OP_FILL_WR: begin
            anc_wr_en   = 1'b1;
            anc_wr_addr = anc_addr(u_ff, 32'(lvl_ff) + 32'd1);
            anc_wr_data = anc_rd_ff;
         end
         OP_RD_U: begin
            node_rd_en = 1'b1;
         end
         OP_RD_V: begin
            node_rd_en   = 1'b1;
            node_rd_addr = v_ff;
         end
         OP_CLIMB_START: begin
            anc_rd_en   = 1'b1;
            anc_rd_addr = anc_addr(u_ff, 32'(TOP_LVL));
         end
         OP_CLIMB_NODE, OP_FIN_ANC: begin
            node_rd_en   = 1'b1;
            node_rd_addr = anc_rd_ff;
         end
         OP_CLIMB_TEST: begin
            anc_rd_en   = 1'b1;
            anc_rd_addr = anc_addr(climb_u, 32'(test_lvl));
         end
         default: begin
         end
      endcase
   end

   // Node table
   always_ff @(posedge clock) begin
      if (node_wr_en) begin
         node_mem[u_ff] <= ld_rec_ff;
      end
      if (node_rd_en) begin
         node_rd_ff <= node_mem[node_rd_addr];
      end
   end

   // Ancestor table
   always_ff @(posedge clock) begin
      if (anc_wr_en) begin
         anc_mem[anc_wr_addr] <= anc_wr_data;
      end
      if (anc_rd_en) begin
         anc_rd_ff <= anc_mem[anc_rd_addr];
      end
   end

   // Next values of the working registers
   always_comb begin
      u_in         = u_ff;
      v_in         = v_ff;
      cur_in       = cur_ff;
      l_in         = l_ff;
      raw_ok_in    = raw_ok_ff;
      ld_rec_in    = ld_rec_ff;
      u_rec_in     = u_rec_ff;
      v_rec_in     = v_rec_ff;
      sum_in       = sum_ff;
      dl_in        = dl_ff;
      lvl_in       = lvl_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (op)
         OP_CAPTURE: begin
            u_in                    = node_of(req_data.node_a);
            v_in                    = node_of(req_data.node_b);
            raw_ok_in               = (32'(req_data.node_a) < 32'(MAX_NODES));
            ld_rec_in.entry_time    = req_data.entry_time;
            ld_rec_in.exit_time     = req_data.exit_time;
            ld_rec_in.root_distance = req_data.root_distance;
         end
         OP_NODE_WR: begin
            cur_in = v_ff;
            lvl_in = '0;
         end
         OP_FILL_WR: begin
            cur_in = anc_rd_ff;
            lvl_in = lvl_ff + 1'b1;
         end
         OP_RD_V: begin
            u_rec_in = node_rd_ff;
         end
         OP_PICK_U: begin
            v_rec_in = node_rd_ff;
            sum_in   = LEN_W'(u_rec_ff.root_distance) + LEN_W'(node_rd_ff.root_distance);
            l_in     = u_ff;
            dl_in    = u_rec_ff.root_distance;
         end
         OP_PICK_V: begin
            v_rec_in = node_rd_ff;
            sum_in   = LEN_W'(u_rec_ff.root_distance) + LEN_W'(node_rd_ff.root_distance);
            l_in     = v_ff;
            dl_in    = node_rd_ff.root_distance;
         end
         OP_CLIMB_START: begin
            v_rec_in = node_rd_ff;
            sum_in   = LEN_W'(u_rec_ff.root_distance) + LEN_W'(node_rd_ff.root_distance);
            lvl_in   = TOP_LVL;
         end
         OP_CLIMB_TEST: begin
            u_in   = climb_u;
            lvl_in = test_lvl;
         end
         OP_FIN_ANC: begin
            l_in = anc_rd_ff;
         end
         OP_FIN_NODE: begin
            dl_in = node_rd_ff.root_distance;
         end
         OP_RSP_LOAD: begin
            rsp_data_in.common_ancestor = l_wide[NODE_W-1:0];
            rsp_data_in.path_length     = len;
            rsp_valid_in                = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         lvl_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         lvl_ff       <= lvl_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      u_ff        <= u_in;
      v_ff        <= v_in;
      cur_ff      <= cur_in;
      l_ff        <= l_in;
      raw_ok_ff   <= raw_ok_in;
      ld_rec_ff   <= ld_rec_in;
      u_rec_ff    <= u_rec_in;
      v_rec_ff    <= v_rec_in;
      sum_ff      <= sum_in;
      dl_ff       <= dl_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Status to the controller
   always_comb begin
      status.is_query  = (req_data.command == CMD_QUERY);
      status.raw_ok    = raw_ok_ff;
      status.same_uv   = (u_ff == v_ff);
      status.cov_uv    = (u_rec_ff.entry_time <= node_rd_ff.entry_time) &&
                         (u_rec_ff.exit_time  >= node_rd_ff.exit_time);
      status.cov_vu    = (node_rd_ff.entry_time <= u_rec_ff.entry_time) &&
                         (node_rd_ff.exit_time  >= u_rec_ff.exit_time);
      status.lvl_zero  = lvl_zero;
      status.fill_last = (lvl_ff == FILL_LAST_LVL);
      status.one_level = (LEVELS == 1);
      status.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== hdl/tpl_ctrl.sv =====
// Controller: sequences loads, ancestor row fills and lifting queries over the datapath.
`default_nettype none

module tpl_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire tpl_pkg::dp_status_type status,
   output tpl_pkg::dp_op_type          op
);
   import tpl_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LD_WR,
      ST_FILL_RD,
      ST_FILL_WR,
      ST_Q_RD_U,
      ST_Q_RD_V,
      ST_Q_DEC,
      ST_C_NODE,
      ST_C_TEST,
      ST_F_ANC,
      ST_F_NODE,
      ST_CALC
   } state_type;

   state_type state_ff, state_in;

   // Next state and datapath operation
   always_comb begin
      state_in = state_ff;
      op       = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op       = OP_CAPTURE;
               state_in = status.is_query ? ST_Q_RD_U : ST_LD_WR;
            end
         end
         ST_LD_WR: begin
            // loads beyond the table are dropped
            if (status.raw_ok) begin
               op = OP_NODE_WR;
            end
            state_in = (!status.raw_ok || status.one_level) ? ST_IDLE : ST_FILL_RD;
         end
         ST_FILL_RD: begin
            op       = OP_FILL_RD;
            state_in = ST_FILL_WR;
         end
         ST_FILL_WR: begin
            op       = OP_FILL_WR;
            state_in = status.fill_last ? ST_IDLE : ST_FILL_RD;
         end
         ST_Q_RD_U: begin
            op       = OP_RD_U;
            state_in = ST_Q_RD_V;
         end
         ST_Q_RD_V: begin
            op       = OP_RD_V;
            state_in = ST_Q_DEC;
         end
         ST_Q_DEC: begin
            // one endpoint above the other ends the search at once
            if (status.same_uv || status.cov_uv) begin
               op       = OP_PICK_U;
               state_in = ST_CALC;
            end else if (status.cov_vu) begin
               op       = OP_PICK_V;
               state_in = ST_CALC;
            end else begin
               op       = OP_CLIMB_START;
               state_in = ST_C_NODE;
            end
         end
         ST_C_NODE: begin
            op       = OP_CLIMB_NODE;
            state_in = ST_C_TEST;
         end
         ST_C_TEST: begin
            op       = OP_CLIMB_TEST;
            state_in = status.lvl_zero ? ST_F_ANC : ST_C_NODE;
         end
         ST_F_ANC: begin
            op       = OP_FIN_ANC;
            state_in = ST_F_NODE;
         end
         ST_F_NODE: begin
            op       = OP_FIN_NODE;
            state_in = ST_CALC;
         end
         ST_CALC: begin
            if (status.rsp_free) begin
               op       = OP_RSP_LOAD;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

`default_nettype wire

// ===== hdl/tree_path_length_lca.sv =====
// Top level: lowest common ancestor and weighted path length by binary lifting.
// Load word: node row and level-0 ancestor write, then one ancestor table read and write
//   per higher level, before the next word can be taken.
// Query word: result registered straight after the endpoint reads when one endpoint covers
//   the other, else after a climb with one ancestor read and one node read per level;
//   a full result register holds the query until it drains, then the next word is taken.
// Reset clears the controller and the result valid; the tables hold nothing defined
//   until loaded and get no clearing pass.
`default_nettype none

module tree_path_length_lca #(
   parameter int MAX_NODES = tpl_pkg::MAX_NODES_DEF,
   parameter int LEVELS    = tpl_pkg::LEVELS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire tpl_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output tpl_pkg::rsp_type      rsp_data
);
   import tpl_pkg::*;

   dp_op_type     op;
   dp_status_type status;

   // Sequencer
   tpl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .op        (op)
   );

   // Tables and arithmetic
   tpl_datapath #(
      .MAX_NODES (MAX_NODES),
      .LEVELS    (LEVELS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .op        (op),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== dv/tpl_tb_pkg.sv =====
// Scoreboard class: binary-lifting predictor and result checker for the path-length engine.
`timescale 1ns / 100ps

package tpl_tb_pkg;
   import tpl_pkg::*;

   localparam int NODES  = MAX_NODES_DEF;
   localparam int LEVELS = LEVELS_DEF;

   class path_scoreboard;
      // Mirror of the node tables and the ancestor rows
      logic [TIME_W-1:0] enter_at  [NODES];
      logic [TIME_W-1:0] leave_at  [NODES];
      logic [DIST_W-1:0] root_dist [NODES];
      logic [NODE_W-1:0] jump      [NODES][LEVELS];
      rsp_type           answer_q  [$];
      int                errors;

      function new();
         errors = 0;
      endfunction

      task report_mismatch(string msg);
         errors++;
         // keep the log short on a badly broken design
         if (errors <= 100) begin
            $display("ERROR at %0t: %s", $time, msg);
         end
      endtask

      // Out-of-range node numbers fold onto the sentinel
      function int unsigned clamp_node(logic [NODE_W-1:0] raw);
         return (int'(raw) < NODES) ? int'(raw) : 0;
      endfunction

      function int unsigned lift(int unsigned n, int lvl);
         return clamp_node(jump[n][lvl]);
      endfunction

      // a is an ancestor of b (or b itself) by the entry/exit window
      function bit is_above(int unsigned a, int unsigned b);
         return enter_at[a] <= enter_at[b] && leave_at[a] >= leave_at[b];
      endfunction

      // Lowest common ancestor, climbing from the top level down
      function int unsigned meet(int unsigned u, int unsigned v);
         int unsigned w;
         if (u == v || is_above(u, v)) begin
            return u;
         end
         if (is_above(v, u)) begin
            return v;
         end
         for (int i = LEVELS - 1; i >= 0; i--) begin
            w = lift(u, i);
            if (!is_above(w, v)) begin
               u = w;
            end
         end
         return lift(u, 0);
      endfunction

      // Accepted input word: update the tables or queue the answer
      function void note_word(req_type w);
         int unsigned      a, b, c;
         logic [LEN_W-1:0] both, twice;
         rsp_type          guess;
         if (w.command == CMD_LOAD) begin
            a = w.node_a;
            if (a >= NODES) begin
               return;
            end
            b = clamp_node(w.node_b);
            enter_at[a]  = w.entry_time;
            leave_at[a]  = w.exit_time;
            root_dist[a] = w.root_distance;
            jump[a][0]   = NODE_W'(b);
            for (int j = 1; j < LEVELS; j++) begin
               jump[a][j] = NODE_W'(lift(lift(a, j - 1), j - 1));
            end
         end else begin
            a = clamp_node(w.node_a);
            b = clamp_node(w.node_b);
            c = meet(a, b);
            both  = LEN_W'(root_dist[a]) + LEN_W'(root_dist[b]);
            twice = {root_dist[c], 1'b0};
            guess.common_ancestor = NODE_W'(c);
            // negative lengths clamp to zero
            guess.path_length = (both >= twice) ? both - twice : '0;
            answer_q.insert(answer_q.size(), guess);
         end
      endfunction

      task check_result(rsp_type got);
         rsp_type want;
         if (answer_q.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending: anc %0d len %0d",
                                      got.common_ancestor, got.path_length));
            return;
         end
         want = answer_q.pop_front();
         if (got.common_ancestor !== want.common_ancestor) begin
            report_mismatch($sformatf("common_ancestor %0d, want %0d",
                                      got.common_ancestor, want.common_ancestor));
         end
         if (got.path_length !== want.path_length) begin
            report_mismatch($sformatf("path_length %0d, want %0d",
                                      got.path_length, want.path_length));
         end
      endtask

      function int pending();
         return answer_q.size();
      endfunction
   endclass

endpackage

// ===== dv/tb_tree_path_length_lca.sv =====
// Testbench top: drives tree loads and path queries into the path-length engine and checks results.
`timescale 1ns / 100ps

module tb_tree_path_length_lca;
   import tpl_pkg::*;
   import tpl_tb_pkg::*;

   localparam int RESET_CYCLES = 12;
   localparam int TARGET_WORDS = 500;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 64;
   localparam int LIMIT_CYCLES = 600000;
   localparam int MAX_TREE     = 150;

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   path_scoreboard sb;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_req       = 0;
   int hold_seen      = 0;
   int hold_left      = 0;
   int words_sent     = 0;
   int cycle_count    = 0;

   // Nodes loaded so far; queries and parents only ever use these
   bit                is_loaded [NODES];
   logic [NODE_W-1:0] loaded_ids[$];

   // Current random tree in preorder, index 0 is the sentinel
   logic [NODE_W-1:0] tree_node   [MAX_TREE + 1];
   int                tree_parent [MAX_TREE + 1];
   int                tree_exit   [MAX_TREE + 1];
   logic [DIST_W-1:0] tree_dist   [MAX_TREE + 1];
   int                id_pool     [NODES - 1];

   tree_path_length_lca uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("tb_tree_path_length_lca NOT OK");
         $finish;
      end
   end

   // Result side: check accepted words, random stalls, long hold-off on request
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_result(rsp_data);
      end
      if (hold_req != hold_seen) begin
         hold_seen = hold_req;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic set_idle(idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            recv_stall_pct <= 0;
         end
         IDLE_SEND: begin
            send_idle_pct = 71;
            recv_stall_pct <= 0;
         end
         IDLE_RECV: begin
            send_idle_pct = 0;
            recv_stall_pct <= 71;
         end
         default: begin
            send_idle_pct = 29;
            recv_stall_pct <= 29;
         end
      endcase
   endtask

   // Offer one word, hold it until taken, then feed the predictor
   task automatic send_word(req_type w);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < send_idle_pct) begin
         gap++;
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      sb.note_word(w);
      words_sent++;
   endtask

   task automatic send_load(logic [NODE_W-1:0] node, logic [NODE_W-1:0] parent,
                            logic [TIME_W-1:0] enter, logic [TIME_W-1:0] leave,
                            logic [DIST_W-1:0] weight);
      req_type w;
      w.command       = CMD_LOAD;
      w.node_a        = node;
      w.node_b        = parent;
      w.entry_time    = enter;
      w.exit_time     = leave;
      w.root_distance = weight;
      send_word(w);
      if (!is_loaded[node]) begin
         is_loaded[node] = 1'b1;
         loaded_ids.insert(loaded_ids.size(), node);
      end
   endtask

   // Load-only fields carry junk on a query
   task automatic send_query(logic [NODE_W-1:0] u, logic [NODE_W-1:0] v);
      req_type w;
      w.command       = CMD_QUERY;
      w.node_a        = u;
      w.node_b        = v;
      w.entry_time    = TIME_W'($urandom_range(0, 1024));
      w.exit_time     = TIME_W'($urandom_range(0, 1024));
      w.root_distance = $urandom;
      send_word(w);
   endtask

   function automatic logic [NODE_W-1:0] any_loaded();
      return loaded_ids[$urandom_range(0, loaded_ids.size() - 1)];
   endfunction

   // Query within the first upto+1 nodes of the current tree, sometimes across trees
   task automatic query_tree(int upto);
      logic [NODE_W-1:0] u, v;
      u = tree_node[$urandom_range(0, upto)];
      v = tree_node[$urandom_range(0, upto)];
      if ($urandom_range(99) < 10) begin
         v = any_loaded();
      end
      if ($urandom_range(99) < 5) begin
         v = u;
      end
      send_query(u, v);
   endtask

   // Stray load: random node, random times, parent is itself or any loaded node
   task automatic send_noise_load();
      logic [NODE_W-1:0] node, parent;
      node   = NODE_W'($urandom_range(1, NODES - 1));
      parent = ($urandom_range(99) < 20) ? node : any_loaded();
      send_load(node, parent, TIME_W'($urandom_range(0, 1024)),
                TIME_W'($urandom_range(0, 1024)), $urandom);
   endtask

   // Main stimulus
   initial begin
      int                n, tree_no, pick, tmp, pop_pct;
      int                stack[$];
      logic [DIST_W-1:0] wmax;

      sb = new();
      for (int k = 0; k < NODES - 1; k++) begin
         id_pool[k] = k + 1;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes and corner cases on a hand-built tree
      set_idle(IDLE_NONE);
      send_load(10'd0,    10'd0,    11'd0,    11'd1024, 32'd0);
      send_load(10'd1023, 10'd0,    11'd1,    11'd3,    32'hFFFF_FFFF);
      // child nearer the root than its parent: lengths go negative
      send_load(10'd512,  10'd1023, 11'd2,    11'd2,    32'd0);
      send_load(10'd341,  10'd1023, 11'd3,    11'd3,    32'hFFFF_FFFF);
      send_load(10'd682,  10'd0,    11'd1024, 11'd1024, 32'hFFFF_FFFF);
      // node that is its own parent
      send_load(10'd7,    10'd7,    11'd5,    11'd5,    32'd100);
      send_query(10'd1023, 10'd682);
      send_query(10'd512,  10'd1023);
      send_query(10'd1023, 10'd512);
      send_query(10'd512,  10'd341);
      send_query(10'd341,  10'd341);
      send_query(10'd0,    10'd682);
      send_query(10'd682,  10'd0);
      send_query(10'd7,    10'd341);
      send_query(10'd341,  10'd7);
      send_query(10'd0,    10'd0);
      send_query(10'd7,    10'd7);
      // reload under a different parent
      send_load(10'd512,  10'd341,  11'd3,    11'd3,    32'd5);
      send_query(10'd512,  10'd341);
      send_query(10'd682,  10'd512);

      // Result side holds off while queries keep coming, so the input backs up
      hold_req <= hold_req + 1;
      repeat (12) begin
         send_query(any_loaded(), any_loaded());
      end

      // Random trees: preorder loads with queries mixed in, plus some stray loads
      tree_no = 0;
      while (words_sent < TARGET_WORDS) begin
         set_idle(idle_mode_type'(tree_no % 4));
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(60, MAX_TREE)
                                         : $urandom_range(2, 24);
         // distinct node ids from a partial shuffle
         for (int k = 0; k < n; k++) begin
            pick = $urandom_range(k, NODES - 2);
            tmp           = id_pool[k];
            id_pool[k]    = id_pool[pick];
            id_pool[pick] = tmp;
            tree_node[k + 1] = NODE_W'(id_pool[k]);
         end
         tree_node[0]   = '0;
         tree_parent[0] = 0;
         tree_dist[0]   = '0;
         // random preorder shape; exit time is the last entry in the subtree
         pop_pct = $urandom_range(10, 60);
         wmax    = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : 32'd1000;
         stack.delete();
         stack.insert(stack.size(), 0);
         for (int k = 1; k <= n; k++) begin
            while (stack.size() > 1 && $urandom_range(99) < pop_pct) begin
               tree_exit[stack[$]] = k - 1;
               void'(stack.pop_back());
            end
            tree_parent[k] = stack[$];
            tree_dist[k]   = tree_dist[stack[$]] + DIST_W'($urandom_range(0, wmax));
            stack.insert(stack.size(), k);
         end
         while (stack.size() > 1) begin
            tree_exit[stack[$]] = n;
            void'(stack.pop_back());
         end
         tree_exit[0] = n + 1;

         for (int k = 0; k <= n; k++) begin
            send_load(tree_node[k], tree_node[tree_parent[k]], TIME_W'(k),
                      TIME_W'(tree_exit[k]), tree_dist[k]);
            if ($urandom_range(99) < 40) begin
               query_tree(k);
            end
            if ($urandom_range(99) < 5) begin
               send_noise_load();
            end
         end
         repeat (n / 2 + 4) begin
            if ($urandom_range(99) < 8) begin
               send_noise_load();
            end else begin
               query_tree(n);
            end
         end
         tree_no++;
      end

      // Drain and finish
      req_valid <= 1'b0;
      set_idle(IDLE_NONE);
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb_tree_path_length_lca OK");
      end else begin
         $display("tb_tree_path_length_lca NOT OK");
      end
      $finish;
   end

endmodule
